// ----- rtl/pdens_pkg.sv -----
// ----------------------------------------------------------------------------
// pdens_pkg
// Shared types and constants of the polyline densifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pdens_pkg;

  // coordinate lanes: x, y, z, m
  localparam int NLANE  = 4;
  localparam int LANE_W = 2;
  localparam int COORD_W = 32;
  localparam int DIFF_W  = 33;

  // configuration register indexes
  localparam logic [2:0] REG_MODE    = 3'd0;
  localparam logic [2:0] REG_EXTRA   = 3'd1;
  localparam logic [2:0] REG_SPACING = 3'd2;
  localparam logic [2:0] REG_USE_Z   = 3'd3;
  localparam logic [2:0] REG_USE_M   = 3'd4;

  // lane indexes
  localparam logic [LANE_W-1:0] LANE_X = 2'd0;
  localparam logic [LANE_W-1:0] LANE_M = 2'd3;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SEARCH,
    S_DIV,
    S_START,
    S_INTERP,
    S_END
  } state_t;

endpackage

// ----- rtl/polyline_densify.sv -----
// ----------------------------------------------------------------------------
// polyline_densify
// Streaming linear densification of polylines with one shared multiplier,
// one shared bit-serial divider and a small sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Vertices enter one word at a time; the block holds the previous vertex and,
// when a segment closes, emits its start vertex, n rounded interpolated
// vertices and, on line_end, the end vertex. in_ready is high only in idle.
// A first vertex that does not end the line is only stored. A segment is
// accepted, then in distance mode goes through the multiplier and the search
// (the square-compare loop), then, if n > 0, through the bit-serial divider
// (one quotient bit per cycle, one division per coordinate), then emits its
// words as the output side takes them (n+1, plus one for the line's end
// vertex). A lone end vertex is emitted on its own.
module polyline_densify #(
  parameter int MAX_EXTRA = 30
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_we,
  input  logic [2:0]                     cfg_addr,
  input  logic [30:0]                    cfg_wdata,
  // input words
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [31:0]             vx,
  input  logic signed [31:0]             vy,
  input  logic signed [31:0]             vz,
  input  logic signed [31:0]             vm,
  input  logic                           line_end,
  // output words
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [31:0]             ox,
  output logic signed [31:0]             oy,
  output logic signed [31:0]             oz,
  output logic signed [31:0]             om,
  output logic                           run_last,
  output logic                           line_done,
  output logic                           clipped
);
  import pdens_pkg::*;

  localparam int NC_W      = $clog2(MAX_EXTRA + 2);
  localparam int CW        = (NC_W > 5) ? NC_W : 5;
  localparam int ACC_W     = 64 + 2 * NC_W;
  localparam int SUM_W     = 65;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int DIV_STEPS = DIFF_W;
  localparam int BC_W      = $clog2(DIV_STEPS + 1);
  localparam logic [NC_W-1:0] K_MAX = NC_W'(MAX_EXTRA + 1);
  localparam logic [NC_W-1:0] N_MAX = NC_W'(MAX_EXTRA);

  // configuration registers
  logic        mode;
  logic [4:0]  extra_nodes;
  logic [30:0] spacing;
  logic        use_z;
  logic        use_m;

  // vertex state
  state_t state, state_next;
  logic                       have_prev;
  logic signed [COORD_W-1:0]  prev_c [NLANE];
  logic signed [COORD_W-1:0]  cur_c  [NLANE];
  logic                       last;
  logic [DIFF_W-1:0]          dmag   [NLANE];
  logic                       dneg   [NLANE];
  logic [NC_W-1:0]            nn;
  logic                       clip;

  // shared multiplier and search
  logic [1:0]        mstep;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  dsum;
  logic [ACC_W-1:0]  s2, acc, inc, acc_next;
  logic [NC_W-1:0]   k;
  logic [DIFF_W-1:0] mul_a;
  logic              srch_stop;
  logic [NC_W-1:0]   n_found;

  // shared divider
  logic [LANE_W-1:0] lane;
  logic [BC_W-1:0]   bcnt;
  logic [DIFF_W-1:0] dq;
  logic [NC_W-1:0]   drem;
  logic [NC_W:0]     trial;
  logic              trial_ge;
  logic [NC_W-1:0]   den;

  // interpolation lanes
  logic [DIFF_W-1:0] q0 [NLANE];
  logic [NC_W-1:0]   r0 [NLANE];
  logic [DIFF_W-1:0] q  [NLANE];
  logic [NC_W-1:0]   r  [NLANE];
  logic signed [COORD_W-1:0] ival [NLANE];
  logic [NC_W-1:0]   j;

  // control
  logic can_emit, emit, accept, is_last_word;
  logic [NC_W-1:0] n_count;
  logic [CW-1:0]   ext_w;
  logic signed [DIFF_W-1:0] din [NLANE];
  logic signed [COORD_W-1:0] vin [NLANE];
  logic signed [COORD_W-1:0] wsel [NLANE];

  assign vin[0] = vx;
  assign vin[1] = vy;
  assign vin[2] = vz;
  assign vin[3] = vm;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= 1'b0;
      extra_nodes <= 5'd1;
      spacing     <= 31'd256;
      use_z       <= 1'b0;
      use_m       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MODE:    mode        <= cfg_wdata[0];
        REG_EXTRA:   extra_nodes <= cfg_wdata[4:0];
        REG_SPACING: spacing     <= cfg_wdata;
        REG_USE_Z:   use_z       <= cfg_wdata[0];
        REG_USE_M:   use_m       <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // count-mode node count, saturated
  assign ext_w   = CW'(extra_nodes);
  assign n_count = (ext_w > CW'(MAX_EXTRA)) ? N_MAX : NC_W'(ext_w);

  // segment differences from the incoming word
  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      din[l] = DIFF_W'(vin[l]) - DIFF_W'(prev_c[l]);
    end
  end

  // multiplier operand select
  always_comb begin
    case (mstep)
      2'd0:    mul_a = dmag[0];
      2'd1:    mul_a = dmag[1];
      default: mul_a = {2'b00, spacing};
    endcase
  end

  // square search step
  assign acc_next  = acc + inc;
  assign srch_stop = (k == K_MAX) || (acc_next > ACC_W'(dsum));
  assign n_found   = (k == K_MAX) ? N_MAX : k;

  // divider step
  assign den      = nn + NC_W'(1);
  assign trial    = {drem, dq[DIFF_W-1]};
  assign trial_ge = trial >= {1'b0, den};

  // interpolated values: a + round(j*d/den), ties away from zero
  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      logic [DIFF_W:0]  rq;
      logic signed [DIFF_W+1:0] sum;
      rq  = {1'b0, q[l]} + (({r[l], 1'b0} >= {1'b0, den}) ? (DIFF_W+1)'(1) : '0);
      sum = (DIFF_W+2)'(prev_c[l]) +
            (dneg[l] ? -(DIFF_W+2)'(signed'({1'b0, rq})) : (DIFF_W+2)'(signed'({1'b0, rq})));
      ival[l] = sum[COORD_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (!have_prev) state_next = line_end ? S_END : S_IDLE;
          else if (mode)  state_next = S_MUL;
          else            state_next = (n_count != '0) ? S_DIV : S_START;
        end
      end
      S_MUL:    if (mstep == 2'd3) state_next = S_SEARCH;
      S_SEARCH: if (srch_stop) state_next = (n_found != '0) ? S_DIV : S_START;
      S_DIV:    if (bcnt == BC_W'(DIV_STEPS) && lane == LANE_M) state_next = S_START;
      S_START: begin
        if (can_emit) begin
          if (nn != '0) state_next = S_INTERP;
          else          state_next = last ? S_END : S_IDLE;
        end
      end
      S_INTERP: if (can_emit && j == nn) state_next = last ? S_END : S_IDLE;
      S_END:    if (can_emit) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // handshake and emit control
  always_comb begin
    in_ready     = (state == S_IDLE);
    accept       = in_valid && in_ready;
    can_emit     = !out_valid || out_ready;
    emit         = can_emit &&
                   (state == S_START || state == S_INTERP || state == S_END);
    is_last_word = 1'b0;
    for (int l = 0; l < NLANE; l++) wsel[l] = cur_c[l];
    case (state)
      S_START: begin
        is_last_word = (nn == '0) && !last;
        for (int l = 0; l < NLANE; l++) wsel[l] = prev_c[l];
      end
      S_INTERP: begin
        is_last_word = (j == nn) && !last;
        for (int l = 0; l < NLANE; l++) wsel[l] = ival[l];
      end
      S_END:   is_last_word = 1'b1;
      default: is_last_word = 1'b0;
    endcase
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      have_prev <= 1'b0;
      out_valid <= 1'b0;
      for (int l = 0; l < NLANE; l++) prev_c[l] <= '0;
    end else begin
      state <= state_next;

      case (state)
        S_IDLE: begin
          if (accept) begin
            for (int l = 0; l < NLANE; l++) begin
              cur_c[l] <= vin[l];
              dneg[l]  <= din[l][DIFF_W-1];
              dmag[l]  <= din[l][DIFF_W-1] ? -din[l] : din[l];
            end
            last  <= line_end;
            nn    <= n_count;
            clip  <= 1'b0;
            mstep <= 2'd0;
            lane  <= LANE_X;
            bcnt  <= '0;
            if (!have_prev && !line_end) begin
              for (int l = 0; l < NLANE; l++) prev_c[l] <= vin[l];
              have_prev <= 1'b1;
            end
          end
        end
        S_MUL: begin
          prod  <= PROD_W'(mul_a) * PROD_W'(mul_a);
          mstep <= mstep + 2'd1;
          if (mstep == 2'd1) dsum <= prod[SUM_W-1:0];
          if (mstep == 2'd2) dsum <= dsum + prod[SUM_W-1:0];
          if (mstep == 2'd3) begin
            s2  <= ACC_W'(prod);
            inc <= ACC_W'(prod);
            acc <= '0;
            k   <= '0;
          end
        end
        S_SEARCH: begin
          if (srch_stop) begin
            nn   <= n_found;
            clip <= (k == K_MAX);
          end else begin
            acc <= acc_next;
            inc <= inc + {s2[ACC_W-2:0], 1'b0};
            k   <= k + NC_W'(1);
          end
        end
        S_DIV: begin
          if (bcnt == '0) begin
            dq   <= dmag[lane];
            drem <= '0;
            bcnt <= bcnt + BC_W'(1);
          end else if (bcnt == BC_W'(DIV_STEPS)) begin
            q0[lane] <= {dq[DIFF_W-2:0], trial_ge};
            q[lane]  <= {dq[DIFF_W-2:0], trial_ge};
            r0[lane] <= trial_ge ? NC_W'(trial - {1'b0, den}) : NC_W'(trial);
            r[lane]  <= trial_ge ? NC_W'(trial - {1'b0, den}) : NC_W'(trial);
            lane     <= lane + LANE_W'(1);
            bcnt     <= '0;
          end else begin
            dq   <= {dq[DIFF_W-2:0], trial_ge};
            drem <= trial_ge ? NC_W'(trial - {1'b0, den}) : NC_W'(trial);
            bcnt <= bcnt + BC_W'(1);
          end
        end
        S_START: begin
          if (can_emit) j <= NC_W'(1);
        end
        S_INTERP: begin
          if (can_emit) begin
            j <= j + NC_W'(1);
            for (int l = 0; l < NLANE; l++) begin
              logic [NC_W:0] rs;
              rs = {1'b0, r[l]} + {1'b0, r0[l]};
              if (rs >= {1'b0, den}) begin
                r[l] <= NC_W'(rs - {1'b0, den});
                q[l] <= q[l] + q0[l] + DIFF_W'(1);
              end else begin
                r[l] <= NC_W'(rs);
                q[l] <= q[l] + q0[l];
              end
            end
          end
        end
        S_END: begin
          if (can_emit) have_prev <= 1'b0;
        end
        default: ;
      endcase

      // segment finished without ending the line: end becomes start
      if (can_emit && !last &&
          ((state == S_START && nn == '0) || (state == S_INTERP && j == nn))) begin
        for (int l = 0; l < NLANE; l++) prev_c[l] <= cur_c[l];
      end

      // output register; a taken word is dropped unless a new one replaces it
      if (emit) begin
        out_valid <= 1'b1;
        ox        <= wsel[0];
        oy        <= wsel[1];
        oz        <= use_z ? wsel[2] : '0;
        om        <= use_m ? wsel[3] : '0;
        run_last  <= is_last_word;
        line_done <= (state == S_END);
        clipped   <= clip && have_prev;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // line's final vertex always closes the run
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && line_done |-> run_last)
    else $error("line_done without run_last");

  // a closing segment keeps the block busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (have_prev || line_end) |=> !in_ready)
    else $error("ready right after a segment word");

  // saturation is only flagged in distance mode
  a_clip_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |-> mode)
    else $error("clipped outside distance mode");

  // interpolation index stays within the node count
  a_j_range: assert property (@(posedge clk) disable iff (rst)
    state == S_INTERP |-> (j != '0) && (j <= nn))
    else $error("interpolation index out of range");
`endif

endmodule

// ----- tb/tb_polyline_densify.sv -----
// ----------------------------------------------------------------------------
// tb_polyline_densify
// Self-checking bench for the polyline densifier: directed and random vertex
// streams in count and distance mode, with random gaps on both handshakes,
// compared word by word against a behavioral predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_polyline_densify;
  import pdens_pkg::*;

  localparam int MAXN = 30;

  typedef struct {
    logic signed [31:0] x, y, z, m;
    logic run_last, line_done, clipped;
  } vtx_word_t;

  // scoreboard: tracks the predicted densified stream
  class densify_sb;
    bit        mode_dist;
    bit [4:0]  extra;
    bit [30:0] spacing;
    bit        use_z, use_m;
    longint    px, py, pz, pm;
    bit        have_prev;
    vtx_word_t pending[$];
    int        errors;
    int        matched;

    function void reset_state();
      mode_dist = 0; extra = 1; spacing = 256; use_z = 0; use_m = 0;
      px = 0; py = 0; pz = 0; pm = 0; have_prev = 0;
      pending.delete(); errors = 0; matched = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [30:0] val);
      case (idx)
        REG_MODE:    mode_dist = val[0];
        REG_EXTRA:   extra = val[4:0];
        REG_SPACING: spacing = val;
        REG_USE_Z:   use_z = val[0];
        REG_USE_M:   use_m = val[0];
        default: ;
      endcase
    endfunction

    // rounded a + k*(b-a)/den, ties away from zero
    function longint lerp(longint a, longint b, longint k, longint den);
      longint num, u, q;
      num = k * (b - a);
      u = (num < 0) ? -num : num;
      q = (2 * u + den) / (2 * den);
      return a + ((num < 0) ? -q : q);
    endfunction

    function void emit(longint x, longint y, longint z, longint m, bit done, bit clip);
      vtx_word_t w;
      w.x = x[31:0]; w.y = y[31:0];
      w.z = use_z ? z[31:0] : 32'sd0;
      w.m = use_m ? m[31:0] : 32'sd0;
      w.run_last = 0; w.line_done = done; w.clipped = clip;
      pending.push_back(w);
    endfunction

    function void note_vertex(logic signed [31:0] vx, vy, vz, vm, logic last);
      longint x, y, z, m, n, ax, ay;
      bit [127:0] len2, t2;
      bit [95:0] t;
      bit clip;
      x = vx; y = vy; z = vz; m = vm; clip = 0;
      if (!have_prev) begin
        if (last) begin
          emit(x, y, z, m, 1, 0);
          pending[$].run_last = 1;
        end else begin
          px = x; py = y; pz = z; pm = m; have_prev = 1;
        end
        return;
      end
      if (mode_dist) begin
        ax = (x > px) ? x - px : px - x;
        ay = (y > py) ? y - py : py - y;
        len2 = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
        n = 0;
        for (int k = 1; k <= MAXN + 1; k++) begin
          t = 96'(k) * 96'(spacing);
          t2 = 128'(t) * 128'(t);
          if (t2 > len2) break;
          n = k;
        end
        if (n > MAXN) begin
          n = MAXN; clip = 1;
        end
      end else begin
        n = (extra > MAXN) ? MAXN : extra;
      end
      emit(px, py, pz, pm, 0, clip);
      for (longint j = 1; j <= n; j++)
        emit(lerp(px, x, j, n + 1), lerp(py, y, j, n + 1),
             lerp(pz, z, j, n + 1), lerp(pm, m, j, n + 1), 0, clip);
      if (last) begin
        emit(x, y, z, m, 1, clip);
        have_prev = 0;
      end else begin
        px = x; py = y; pz = z; pm = m;
      end
      pending[$].run_last = 1;
    endfunction

    function void check_word(vtx_word_t a);
      vtx_word_t e;
      if (pending.size() == 0) begin
        $error("unexpected word x=%0d y=%0d", a.x, a.y);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.x !== e.x) begin $error("ox exp %0d got %0d", e.x, a.x); errors++; end
      if (a.y !== e.y) begin $error("oy exp %0d got %0d", e.y, a.y); errors++; end
      if (a.z !== e.z) begin $error("oz exp %0d got %0d", e.z, a.z); errors++; end
      if (a.m !== e.m) begin $error("om exp %0d got %0d", e.m, a.m); errors++; end
      if (a.run_last !== e.run_last) begin
        $error("run_last exp %0b got %0b", e.run_last, a.run_last); errors++;
      end
      if (a.line_done !== e.line_done) begin
        $error("line_done exp %0b got %0b", e.line_done, a.line_done); errors++;
      end
      if (a.clipped !== e.clipped) begin
        $error("clipped exp %0b got %0b", e.clipped, a.clipped); errors++;
      end
      matched++;
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [2:0] cfg_addr = '0;
  logic [30:0] cfg_wdata = '0;
  logic in_valid = 0, in_ready;
  logic signed [31:0] vx = 0, vy = 0, vz = 0, vm = 0;
  logic line_end = 0;
  logic out_valid, out_ready = 0;
  logic signed [31:0] ox, oy, oz, om;
  logic run_last, line_done, clipped;

  densify_sb sb;
  int  cycles = 0;
  int  words_sent = 0;
  bit  hold_off = 0;   // long receiver stall request

  polyline_densify #(.MAX_EXTRA(MAXN)) DUT (.*);

  always #2 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int w;
    @(posedge clk iff !rst);
    forever begin
      if (hold_off) begin
        out_ready <= 0;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if ($urandom_range(0, 5) == 0) w = 0;
      if (w > 0) begin
        out_ready <= 0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
      sb.check_word('{ox, oy, oz, om, run_last, line_done, clipped});
    end
  end

  // valid stays up into the next word when there is no gap
  task automatic send_vertex(logic signed [31:0] x, y, z, m, logic last, bit busy);
    int w;
    w = busy ? 0 : $urandom_range(0, 16);
    if (!busy && $urandom_range(0, 2) == 0) w = 0;
    if (w > 0) begin
      in_valid <= 0;
      repeat (w) @(posedge clk);
    end
    in_valid <= 1; vx <= x; vy <= y; vz <= z; vm <= m; line_end <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_vertex(x, y, z, m, last);
    words_sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);   // block may still be finishing a first vertex
  endtask

  task automatic set_reg(logic [2:0] idx, logic [30:0] val);
    cfg_we <= 1; cfg_addr <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] rnd_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 4000)) - 2000;
      2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 200000)) - 100000;
    endcase
  endfunction

  // random line: mostly 2..6 vertices, near neighbors
  task automatic random_line(bit busy);
    int nv;
    logic signed [31:0] x, y, z, m;
    nv = $urandom_range(1, 6);
    x = rnd_coord(); y = rnd_coord(); z = $urandom; m = $urandom;
    for (int i = 0; i < nv; i++) begin
      send_vertex(x, y, z, m, i == nv - 1, busy);
      if ($urandom_range(0, 3) == 0) begin
        x = rnd_coord(); y = rnd_coord();
      end else begin
        x = x + ($signed($urandom_range(0, 20000)) - 10000);
        y = y + ($signed($urandom_range(0, 20000)) - 10000);
      end
      z = $urandom; m = $urandom;
    end
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: reset config, lone vertex, extremes
    send_vertex(32'sd5, -32'sd7, 32'sd9, 32'sd11, 1, 0);
    send_vertex(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0);
    send_vertex(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0);
    send_vertex(32'sh80000000, 32'sh7fffffff, 32'sd0, -32'sd1, 1, 0);
    drain();
    set_reg(REG_USE_Z, 1); set_reg(REG_USE_M, 1);
    set_reg(REG_EXTRA, 31);
    send_vertex(32'sd0, 32'sd0, 32'sd0, 32'sd0, 0, 0);
    send_vertex(32'sd3100, -32'sd3100, 32'sd15, -32'sd15, 0, 0);
    send_vertex(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 1, 0);
    drain();
    set_reg(REG_EXTRA, 0);
    send_vertex(32'sd1, 32'sd2, 32'sd3, 32'sd4, 0, 0);
    send_vertex(32'sd5, 32'sd6, 32'sd7, 32'sd8, 1, 0);
    drain();
    set_reg(REG_MODE, 1);
    set_reg(REG_SPACING, 0);   // zero spacing saturates
    send_vertex(32'sd0, 32'sd0, 32'sd0, 32'sd0, 0, 0);
    send_vertex(32'sd0, 32'sd0, 32'sd1, 32'sd1, 0, 0);
    drain();
    set_reg(REG_SPACING, 31'h7fffffff);
    send_vertex(32'sh80000000, 32'sh80000000, 32'sd0, 32'sd0, 0, 0);
    send_vertex(32'sh7fffffff, 32'sh7fffffff, 32'sd0, 32'sd0, 1, 0);
    drain();
    set_reg(REG_SPACING, 256);
    send_vertex(32'sd0, 32'sd0, 32'sd0, 32'sd0, 0, 0);
    send_vertex(32'sd768, 32'sd1024, 32'sd0, 32'sd0, 0, 0);  // length exactly 5.0
    send_vertex(32'sd0, 32'sd0, 32'sd0, 32'sd0, 1, 0);
    drain();

    // random phases over several settings
    for (int ph = 0; ph < 8; ph++) begin
      set_reg(REG_MODE, 31'(ph[0]));
      set_reg(REG_EXTRA, (ph == 2) ? 31'd31 : 31'($urandom_range(0, 8)));
      set_reg(REG_SPACING, (ph == 5) ? 31'd1 :
              31'((1 << $urandom_range(8, 14)) + $urandom_range(0, 999)));
      set_reg(REG_USE_Z, 31'($urandom_range(0, 1)));
      set_reg(REG_USE_M, 31'($urandom_range(0, 1)));
      if (ph == 3) hold_off = 1;   // receiver stalls long, input backs up
      while (words_sent < 40 + (ph + 1) * 43) random_line(ph == 3);
      drain();   // sender pauses until all results are in
    end

    $display("Sent %0d vertices, checked %0d output words, count and distance modes.",
             words_sent, sb.matched);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end
endmodule
